// ===== rtl/pbxu_pkg.sv =====
// ----------------------------------------------------------------------------
// pbxu_pkg: shared constants, types and helpers for the periodic box unwrapper
// Widths of the beat fields, the layout of one atom's stored entry and the
// signed saturation used for offsets and unwrapped coordinates.
// ----------------------------------------------------------------------------
package pbxu_pkg;

   // atom store depth, a power of two
   localparam int ATOM_COUNT = 4096;
   localparam int ADDR_W     = (ATOM_COUNT > 1) ? $clog2(ATOM_COUNT) : 1;

   // beat field widths
   localparam int INDEX_W    = 12;
   localparam int COORD_W    = 32;
   localparam int BOX_W      = 31;
   localparam int CUTOFF_W   = 17;
   localparam int FRAC_W     = 16;

   // threshold product cutoff * box and the exact compare width
   localparam int THR_W      = CUTOFF_W + BOX_W;
   localparam int CMP_W      = THR_W + 2;

   localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(32768);
   localparam logic [ADDR_W-1:0]   LAST_ADDR    = ADDR_W'(ATOM_COUNT - 1);

   // one atom's entry in the store
   typedef struct packed {
      logic signed [COORD_W-1:0] prev_x;
      logic signed [COORD_W-1:0] prev_y;
      logic signed [COORD_W-1:0] off_x;
      logic signed [COORD_W-1:0] off_y;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // store address of an atom index (index modulo the store depth)
   function automatic logic [ADDR_W-1:0] store_addr(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W+ADDR_W-1:0] wide;
      wide = {{ADDR_W{1'b0}}, idx};
      return wide[ADDR_W-1:0];
   endfunction

   // clamp a one-bit-grown sum to the signed coordinate range
   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [COORD_W:0] v
   );
      logic signed [COORD_W-1:0] res;
      if (v[COORD_W] != v[COORD_W-1]) begin
         res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         res = v[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/pbxu_req_if.sv =====
// ----------------------------------------------------------------------------
// pbxu_req_if: coordinate beat channel
// One atom's wrapped x/y position and the frame's box lengths per beat.
// ----------------------------------------------------------------------------
interface pbxu_req_if;
   import pbxu_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [INDEX_W-1:0]         atom_index;
   logic                       start_frame;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic [BOX_W-1:0]           box_x;
   logic [BOX_W-1:0]           box_y;

   modport source (
      output valid, atom_index, start_frame, pos_x, pos_y, box_x, box_y,
      input  ready
   );

   modport sink (
      input  valid, atom_index, start_frame, pos_x, pos_y, box_x, box_y,
      output ready
   );

endinterface

// ===== rtl/pbxu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pbxu_rsp_if: unwrapped coordinate beat channel
// Echoed atom index and the unwrapped x/y position per beat.
// ----------------------------------------------------------------------------
interface pbxu_rsp_if;
   import pbxu_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [INDEX_W-1:0]         out_index;
   logic signed [COORD_W-1:0]  unwrapped_x;
   logic signed [COORD_W-1:0]  unwrapped_y;

   modport source (
      output valid, out_index, unwrapped_x, unwrapped_y,
      input  ready
   );

   modport sink (
      input  valid, out_index, unwrapped_x, unwrapped_y,
      output ready
   );

endinterface

// ===== rtl/pbxu_ram.sv =====
// ----------------------------------------------------------------------------
// pbxu_ram: simple dual-port synchronous ram
// One write port and one read port, read data registered.
// A read and a write to the same address on one edge return the old data.
// ----------------------------------------------------------------------------
module pbxu_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pbxu_axis.sv =====
// ----------------------------------------------------------------------------
// pbxu_axis: jump test and offset update for one axis
// Compares the displacement from the stored position against cutoff * box,
// moves the accumulated offset by one box length on a jump and clears it on start_frame.
// ----------------------------------------------------------------------------
module pbxu_axis (
   input  logic                               start_frame,
   input  logic signed [pbxu_pkg::COORD_W-1:0] pos,
   input  logic signed [pbxu_pkg::COORD_W-1:0] prev,
   input  logic signed [pbxu_pkg::COORD_W-1:0] off,
   input  logic [pbxu_pkg::BOX_W-1:0]          box,
   input  logic [pbxu_pkg::THR_W-1:0]          thr,
   output logic signed [pbxu_pkg::COORD_W-1:0] new_off
);
   import pbxu_pkg::*;

   logic signed [COORD_W:0]  disp;
   logic signed [CMP_W-1:0]  disp_scaled;
   logic signed [CMP_W-1:0]  thr_pos;
   logic signed [CMP_W-1:0]  thr_neg;
   logic                     jump_fwd;
   logic                     jump_bwd;
   logic signed [COORD_W:0]  off_minus;
   logic signed [COORD_W:0]  off_plus;

   // displacement at full precision, scaled to the threshold's fraction bits
   assign disp        = {pos[COORD_W-1], pos} - {prev[COORD_W-1], prev};
   assign disp_scaled = {disp[COORD_W], disp, {FRAC_W{1'b0}}};
   assign thr_pos     = {2'b00, thr};
   assign thr_neg     = -thr_pos;

   assign jump_fwd = disp_scaled > thr_pos;
   assign jump_bwd = disp_scaled < thr_neg;

   // both candidate offsets, picked by the jump direction
   assign off_minus = {off[COORD_W-1], off} - {2'b00, box};
   assign off_plus  = {off[COORD_W-1], off} + {2'b00, box};

   always_comb begin
      priority if (start_frame) begin
         new_off = '0;
      end else if (jump_fwd) begin
         new_off = sat_coord(off_minus);
      end else if (jump_bwd) begin
         new_off = sat_coord(off_plus);
      end else begin
         new_off = off;
      end
   end

endmodule

// ===== rtl/periodic_box_xy_unwrap_core.sv =====
// ----------------------------------------------------------------------------
// periodic_box_xy_unwrap_core: periodic box x/y trajectory unwrapper
// Keeps each atom's last raw position and accumulated box offset in one
// on-chip store, corrects box jumps and returns position plus offset.
//
//   channel  dir  payload                                       handshake
//   req_ch   in   atom_index start_frame pos_x pos_y box_x box_y valid/ready
//   rsp_ch   out  out_index unwrapped_x unwrapped_y              valid/ready
//   csr_*    in   cutoff_fraction (17 bits)                      wr_en strobe
//
// One beat per cycle sustained while rsp_ch takes results and no clearing pass runs; each beat
// passes through the store read, offset update and write-back, and output sum in turn.
// After reset a clearing pass walks the store, one entry a cycle, over all ATOM_COUNT
// entries with req_ch.ready low; csr writes are taken throughout.
// Back-to-back beats for the same atom are served by forwarding the last
// write-back. A stalled rsp_ch holds the pipe; ready drops only when full or clearing.
// ----------------------------------------------------------------------------
module periodic_box_xy_unwrap_core (
   input  logic                              clock,
   input  logic                              reset,
   pbxu_req_if.sink                          req_ch,
   pbxu_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [pbxu_pkg::CUTOFF_W-1:0]     csr_wr_data
);
   import pbxu_pkg::*;

   // cutoff register
   logic [CUTOFF_W-1:0] cutoff_ff;

   // clearing pass
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // pipeline handshakes
   logic req_take;
   logic out_free, s2_free, s1_free, s1_move;

   // stage 1: store read in flight, offset update
   logic                      s1_valid_ff, s1_valid_in;
   logic [INDEX_W-1:0]        s1_index_ff;
   logic                      s1_first_ff;
   logic signed [COORD_W-1:0] s1_pos_x_ff, s1_pos_y_ff;
   logic [BOX_W-1:0]          s1_box_x_ff, s1_box_y_ff;
   logic [THR_W-1:0]          s1_thr_x_ff, s1_thr_y_ff;

   // stage 2: position and new offset
   logic                      s2_valid_ff, s2_valid_in;
   logic [INDEX_W-1:0]        s2_index_ff;
   logic signed [COORD_W-1:0] s2_pos_x_ff, s2_pos_y_ff;
   logic signed [COORD_W-1:0] s2_off_x_ff, s2_off_y_ff;

   // stage 3: output register
   logic                      s3_valid_ff, s3_valid_in;
   logic [INDEX_W-1:0]        s3_index_ff;
   logic signed [COORD_W-1:0] s3_ux_ff, s3_uy_ff;

   // last write-back, for forwarding
   logic              wb_valid_ff;
   logic [ADDR_W-1:0] wb_addr_ff;
   entry_type         wb_data_ff;

   // store ports
   logic [ADDR_W-1:0]  s1_addr;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   entry_type          ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          entry_cur;
   logic signed [COORD_W-1:0] new_off_x, new_off_y;
   logic signed [COORD_W:0]   sum_x, sum_y;

   // cutoff register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else if (csr_wr_en) begin
         cutoff_ff <= csr_wr_data;
      end
   end

   // clearing pass sequencer
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // stage advance chain, from the output back
   assign out_free     = !s3_valid_ff || rsp_ch.ready;
   assign s2_free      = !s2_valid_ff || out_free;
   assign s1_free      = !s1_valid_ff || s2_free;
   assign s1_move      = s1_valid_ff && s2_free;
   assign req_ch.ready = !clearing_ff && s1_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign s1_valid_in = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_move  ? 1'b1 : ((s2_valid_ff && out_free) ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = (s2_valid_ff && out_free) ? 1'b1
                      : ((s3_valid_ff && rsp_ch.ready) ? 1'b0 : s3_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // stage 1 capture with the threshold products
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_index_ff <= req_ch.atom_index;
         s1_first_ff <= req_ch.start_frame;
         s1_pos_x_ff <= req_ch.pos_x;
         s1_pos_y_ff <= req_ch.pos_y;
         s1_box_x_ff <= req_ch.box_x;
         s1_box_y_ff <= req_ch.box_y;
         s1_thr_x_ff <= THR_W'(cutoff_ff) * THR_W'(req_ch.box_x);
         s1_thr_y_ff <= THR_W'(cutoff_ff) * THR_W'(req_ch.box_y);
      end
   end

   // atom store
   pbxu_ram #(
      .DEPTH (ATOM_COUNT),
      .WIDTH (ENTRY_W),
      .AW    (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_take),
      .rd_addr (store_addr(req_ch.atom_index)),
      .rd_data (ram_rd_data)
   );

   // forward the last write-back when it hit the same entry
   assign s1_addr   = store_addr(s1_index_ff);
   assign entry_cur = (wb_valid_ff && (wb_addr_ff == s1_addr)) ? wb_data_ff
                                                              : entry_type'(ram_rd_data);

   pbxu_axis u_axis_x (
      .start_frame (s1_first_ff),
      .pos         (s1_pos_x_ff),
      .prev        (entry_cur.prev_x),
      .off         (entry_cur.off_x),
      .box         (s1_box_x_ff),
      .thr         (s1_thr_x_ff),
      .new_off     (new_off_x)
   );

   pbxu_axis u_axis_y (
      .start_frame (s1_first_ff),
      .pos         (s1_pos_y_ff),
      .prev        (entry_cur.prev_y),
      .off         (entry_cur.off_y),
      .box         (s1_box_y_ff),
      .thr         (s1_thr_y_ff),
      .new_off     (new_off_y)
   );

   // write-back: clearing pass or the updated entry
   always_comb begin
      ram_wr_data = '0;
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
      end else begin
         ram_wr_en          = s1_move;
         ram_wr_addr        = s1_addr;
         ram_wr_data.prev_x = s1_pos_x_ff;
         ram_wr_data.prev_y = s1_pos_y_ff;
         ram_wr_data.off_x  = new_off_x;
         ram_wr_data.off_y  = new_off_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (s1_move) begin
         wb_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         wb_addr_ff <= s1_addr;
         wb_data_ff <= ram_wr_data;
      end
   end

   // stage 2 capture
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_index_ff <= s1_index_ff;
         s2_pos_x_ff <= s1_pos_x_ff;
         s2_pos_y_ff <= s1_pos_y_ff;
         s2_off_x_ff <= new_off_x;
         s2_off_y_ff <= new_off_y;
      end
   end

   // position plus offset, saturated
   assign sum_x = {s2_pos_x_ff[COORD_W-1], s2_pos_x_ff} + {s2_off_x_ff[COORD_W-1], s2_off_x_ff};
   assign sum_y = {s2_pos_y_ff[COORD_W-1], s2_pos_y_ff} + {s2_off_y_ff[COORD_W-1], s2_off_y_ff};

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_free) begin
         s3_index_ff <= s2_index_ff;
         s3_ux_ff    <= sat_coord(sum_x);
         s3_uy_ff    <= sat_coord(sum_y);
      end
   end

   // result beat
   assign rsp_ch.valid       = s3_valid_ff;
   assign rsp_ch.out_index   = s3_index_ff;
   assign rsp_ch.unwrapped_x = s3_ux_ff;
   assign rsp_ch.unwrapped_y = s3_uy_ff;

endmodule
